// ----- sv/fnpll_pkg.sv -----
// ----------------------------------------------------------------------------
// Fractional-N PLL register builder package
// Shared types, register codes and constant words for the register builder.
// ----------------------------------------------------------------------------
`default_nettype none

package fnpll_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumWords = 6;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned StepsW  = 28;
  localparam int unsigned ModW    = 12;
  localparam int unsigned RCntW   = 10;
  localparam int unsigned DivLogW = 3;
  localparam int unsigned IntW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned DivCntW = $clog2(StepsW);

  // Power-on default words, index 5 first.
  localparam logic [NumWords-1:0][WordW-1:0] DefaultWords = {
    32'h0058_0005, 32'h00EC_803C, 32'h0004_04B3,
    32'h0001_0E42, 32'h0000_8029, 32'h002C_8018
  };

  localparam logic [WordW-1:0] W0IntMask  = 32'h7FFF_8000;
  localparam logic [WordW-1:0] W0FracMask = 32'h0000_7FF8;
  localparam logic [WordW-1:0] W1ModMask  = 32'h0000_7FF8;
  localparam logic [WordW-1:0] W2RMask    = 32'h00FF_C000;
  localparam logic [WordW-1:0] W2Doubler  = 32'h0200_0000;
  localparam logic [WordW-1:0] W2Half     = 32'h0100_0000;
  localparam logic [WordW-1:0] W4DivMask  = 32'h0070_0000;

  localparam logic [ModW-1:0] ModulusRst  = 12'd5;
  localparam logic [RCntW-1:0] RCntRst    = 10'd4;
  localparam logic [DivLogW-1:0] DivLogRst = 3'd6;

  typedef enum logic [1:0] {
    MODE_RESTORE = 2'd0,
    MODE_CLOCK   = 2'd1,
    MODE_FREQ    = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODULUS    = 3'd0,
    CFG_R_COUNTER  = 3'd1,
    CFG_REF_DOUBLE = 3'd2,
    CFG_REF_HALF   = 3'd3,
    CFG_OUT_DIV    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_EMIT = 2'd2
  } state_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [StepsW-1:0] frequency_steps;
  } in_beat_t;

  typedef struct packed {
    logic [IdxW-1:0]   reg_index;
    logic [WordW-1:0]  reg_word;
    logic [StepsW-1:0] achieved_steps;
    logic              clipped;
    logic              last;
  } out_beat_t;

  // Result of the serial divider, valid in the cycle that done is high.
  typedef struct packed {
    logic              done;
    logic [StepsW-1:0] quot;
    logic [ModW-1:0]   rem;
  } div_res_t;

endpackage

`default_nettype wire

// ----- sv/frac_n_pll_register_builder_top.sv -----
// ----------------------------------------------------------------------------
// Fractional-N PLL register builder
// Keeps the six shadow words of a fractional-N synthesizer and emits the
// words to be shifted into the device for each command beat.
// ----------------------------------------------------------------------------
// Usage: a command beat on the input channel (valid/ready) carries a mode
// and a frequency in resolution steps. Mode 0 restores the default words and
// emits words 5 down to 0; mode 1 merges the clock settings and emits words
// 4, 2, 1 and 0; mode 2 divides the step count by the modulus and emits
// words 1 and 0 together with the achieved step count. Mode 3 is accepted
// and dropped. The configuration port is a plain write port that takes one
// register per cycle; the user must write it only while the block is idle,
// which the block itself does not enforce. Throughput: one command is
// handled at a time. Modes 0 and 1 go straight to the emit state; mode 2
// first runs the serial divider, one quotient bit per cycle, and emits once
// the quotient is complete. Thereafter one result beat leaves per cycle
// while the receiver keeps ready high, and a new command is taken in the
// cycle after the last beat has been loaded into the output register.
// A stalled receiver simply holds the output register; the sequencer waits.
// Reset returns the shadow words and the configuration registers to their
// power-on values and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module frac_n_pll_register_builder_top (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  fnpll_pkg::in_beat_t                in_data_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output fnpll_pkg::out_beat_t               out_data_o,
  input  wire                                cfg_we_i,
  input  wire  [fnpll_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [fnpll_pkg::CfgDataW-1:0]     cfg_data_i
);
  import fnpll_pkg::*;

  // Configuration registers.
  logic [ModW-1:0]    modulus_q;
  logic [RCntW-1:0]   r_counter_q;
  logic               ref_doubler_q;
  logic               ref_half_q;
  logic [DivLogW-1:0] out_div_log2_q;

  // Shadow words of the synthesizer.
  logic [NumWords-1:0][WordW-1:0] shadow_q;

  // Command sequencing.
  state_e            state_q, state_d;
  logic [1:0]        mode_q;
  logic [StepsW-1:0] steps_q;
  logic [IdxW-1:0]   idx_q;
  logic [StepsW-1:0] achieved_q;
  logic              clipped_q;

  // Output register.
  logic      out_valid_q;
  out_beat_t out_data_q;

  logic      in_acc;
  logic      out_load;
  logic      last_word;
  logic      div_start;
  div_res_t  div_res;

  // Saturation handling of the division result.
  logic [ModW-1:0]   mod_eff;
  logic              clip;
  logic [IntW-1:0]   int_val;
  logic [ModW-1:0]   frac_val;
  logic [StepsW-1:0] achieved_val;
  logic [StepsW-1:0] mod_shifted;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_load    = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign last_word   = (idx_q == '0);
  assign div_start   = in_acc && (in_data_i.mode == MODE_FREQ);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  fnpll_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_data_i.frequency_steps),
    .divisor_i  (modulus_q),
    .res_o      (div_res)
  );

  // When INT saturates, INT * m + (m - 1) collapses to m * 2^16 - 1.
  assign mod_eff      = (modulus_q == '0) ? ModW'(1) : modulus_q;
  assign clip         = |div_res.quot[StepsW-1:IntW];
  assign int_val      = clip ? {IntW{1'b1}} : div_res.quot[IntW-1:0];
  assign frac_val     = clip ? (mod_eff - 1'b1) : div_res.rem;
  assign mod_shifted  = {mod_eff, {IntW{1'b0}}};
  assign achieved_val = clip ? (mod_shifted - 1'b1) : steps_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.mode)
            MODE_RESTORE: state_d = ST_EMIT;
            MODE_CLOCK:   state_d = ST_EMIT;
            MODE_FREQ:    state_d = ST_DIV;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load && last_word) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q      <= ModulusRst;
      r_counter_q    <= RCntRst;
      ref_doubler_q  <= 1'b0;
      ref_half_q     <= 1'b0;
      out_div_log2_q <= DivLogRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODULUS:    modulus_q      <= cfg_data_i[ModW-1:0];
        CFG_R_COUNTER:  r_counter_q    <= cfg_data_i[RCntW-1:0];
        CFG_REF_DOUBLE: ref_doubler_q  <= cfg_data_i[0];
        CFG_REF_HALF:   ref_half_q     <= cfg_data_i[0];
        CFG_OUT_DIV:    out_div_log2_q <= cfg_data_i[DivLogW-1:0];
        default: ;
      endcase
    end
  end

  // Shadow words and the per-command fields that ride along with each beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_q   <= DefaultWords;
      mode_q     <= MODE_RESTORE;
      idx_q      <= '0;
      achieved_q <= '0;
      clipped_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_q     <= in_data_i.mode;
        achieved_q <= '0;
        clipped_q  <= 1'b0;
        case (in_data_i.mode)
          MODE_RESTORE: begin
            shadow_q <= DefaultWords;
            idx_q    <= IdxW'(5);
          end
          MODE_CLOCK: begin
            shadow_q[4] <= (shadow_q[4] & ~W4DivMask)
                         | {9'd0, out_div_log2_q, 20'd0};
            shadow_q[2] <= (shadow_q[2] & ~(W2Doubler | W2Half | W2RMask))
                         | {6'd0, ref_doubler_q, ref_half_q, r_counter_q, 14'd0};
            shadow_q[1] <= (shadow_q[1] & ~W1ModMask)
                         | {17'd0, modulus_q, 3'd0};
            idx_q       <= IdxW'(4);
          end
          MODE_FREQ: begin
            idx_q <= IdxW'(1);
          end
          default: ;
        endcase
      end else if (div_res.done) begin
        shadow_q[0] <= (shadow_q[0] & ~(W0IntMask | W0FracMask))
                     | {1'b0, int_val, frac_val, 3'd0};
        achieved_q  <= achieved_val;
        clipped_q   <= clip;
      end else if (out_load && !last_word) begin
        // Clock mode skips word 3; every other sequence counts down.
        if (mode_q == MODE_CLOCK && idx_q == IdxW'(4)) begin
          idx_q <= IdxW'(2);
        end else begin
          idx_q <= idx_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      steps_q <= in_data_i.frequency_steps;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.reg_index      <= idx_q;
      out_data_q.reg_word       <= shadow_q[idx_q];
      out_data_q.achieved_steps <= achieved_q;
      out_data_q.clipped        <= clipped_q;
      out_data_q.last           <= last_word;
    end
  end

endmodule

`default_nettype wire

// ----- sv/fnpll_div.sv -----
// ----------------------------------------------------------------------------
// Fractional-N PLL serial divider
// Restoring divider retiring one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fnpll_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  [fnpll_pkg::StepsW-1:0] dividend_i,
  input  wire  [fnpll_pkg::ModW-1:0]   divisor_i,
  output fnpll_pkg::div_res_t          res_o
);
  import fnpll_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [StepsW-1:0]  num_q;
  logic [ModW-1:0]    rem_q;
  logic [ModW-1:0]    div_q;

  logic [ModW:0]      trial;
  logic [ModW:0]      diff;
  logic               ge;

  // The dividend shifts out at the top while quotient bits shift in below.
  assign trial = {rem_q, num_q[StepsW-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(StepsW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      div_q <= (divisor_i == '0) ? ModW'(1) : divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[StepsW-2:0], ge};
      rem_q <= ge ? diff[ModW-1:0] : trial[ModW-1:0];
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = num_q;
  assign res_o.rem  = rem_q;

endmodule

`default_nettype wire

// ----- tb/sv/frac_n_pll_register_builder_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fractional-N PLL register builder testbench
// Sends command beats in all three modes, plus the unused one, under several
// register settings. A shadow copy of the six synthesizer words predicts
// every result beat, and each beat is compared field by field as it leaves.
// ----------------------------------------------------------------------------

module frac_n_pll_register_builder_top_tb;
  import fnpll_pkg::*;

  // The fourth mode code has no enum member; the block accepts and drops it.
  localparam logic [1:0] ModeUnused = 2'd3;

  // Word positions inside the synthesizer image.
  localparam int unsigned WordFreq = 0;
  localparam int unsigned WordMod  = 1;
  localparam int unsigned WordRef  = 2;
  localparam int unsigned WordDiv  = 4;

  localparam int unsigned MaxIntVal      = 65535;
  // Quiet cycles after the last owed beat has left, before the settings are
  // changed or the next command goes out.
  localparam int unsigned SettleCycles   = 40;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned LongHoldAfter  = 60;
  localparam int unsigned ItemsPerPhase  = 26;
  localparam int unsigned MaxPrinted     = 40;

  // --------------------------------------------------------------------------
  // Shadow of the synthesizer words and the settings, with the queue of
  // result beats still owed by the block.
  // --------------------------------------------------------------------------
  class word_shadow_sb;
    logic [WordW-1:0]   words [NumWords];
    logic [ModW-1:0]    modulus;
    logic [RCntW-1:0]   r_count;
    logic               doubler;
    logic               halver;
    logic [DivLogW-1:0] div_log2;
    out_beat_t          owed [$];
    int unsigned        errors;

    function new();
      restore_words();
      modulus  = ModulusRst;
      r_count  = RCntRst;
      doubler  = 1'b0;
      halver   = 1'b0;
      div_log2 = DivLogRst;
      errors   = 0;
    endfunction

    function void restore_words();
      for (int i = 0; i < NumWords; i++) words[i] = DefaultWords[i];
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_MODULUS:    modulus  = data[ModW-1:0];
        CFG_R_COUNTER:  r_count  = data[RCntW-1:0];
        CFG_REF_DOUBLE: doubler  = data[0];
        CFG_REF_HALF:   halver   = data[0];
        CFG_OUT_DIV:    div_log2 = data[DivLogW-1:0];
        default: ;
      endcase
    endfunction

    function void owe_word(int unsigned idx, logic [StepsW-1:0] steps, logic clip,
                           logic last);
      out_beat_t b;
      b.reg_index      = IdxW'(idx);
      b.reg_word       = words[idx];
      b.achieved_steps = steps;
      b.clipped        = clip;
      b.last           = last;
      owed.push_back(b);
    endfunction

    // Updates the shadow words for one accepted command and queues its beats.
    function void note_command(in_beat_t cmd);
      int unsigned       m;
      int unsigned       q;
      int unsigned       f;
      logic              clip;
      logic [StepsW-1:0] reached;
      case (cmd.mode)
        MODE_RESTORE: begin
          restore_words();
          for (int i = NumWords - 1; i >= 0; i--) owe_word(i, '0, 1'b0, i == 0);
        end
        MODE_CLOCK: begin
          words[WordDiv] = (words[WordDiv] & ~W4DivMask) | (WordW'(div_log2) << 20);
          words[WordRef] = (words[WordRef] & ~(W2Doubler | W2Half | W2RMask))
                         | (WordW'(doubler) << 25) | (WordW'(halver) << 24)
                         | (WordW'(r_count) << 14);
          words[WordMod] = (words[WordMod] & ~W1ModMask) | (WordW'(modulus) << 3);
          owe_word(WordDiv, '0, 1'b0, 1'b0);
          owe_word(WordRef, '0, 1'b0, 1'b0);
          owe_word(WordMod, '0, 1'b0, 1'b0);
          owe_word(WordFreq, '0, 1'b0, 1'b1);
        end
        MODE_FREQ: begin
          // A zero modulus divides as one.
          m    = (modulus == '0) ? 1 : int'(modulus);
          q    = int'(cmd.frequency_steps) / m;
          f    = int'(cmd.frequency_steps) % m;
          clip = 1'b0;
          if (q > MaxIntVal) begin
            q    = MaxIntVal;
            f    = m - 1;
            clip = 1'b1;
          end
          reached = StepsW'(q * m + f);
          words[WordFreq] = (words[WordFreq] & ~(W0IntMask | W0FracMask))
                          | ((WordW'(q) << 15) & W0IntMask)
                          | ((WordW'(f) << 3) & W0FracMask);
          owe_word(WordMod, reached, clip, 1'b0);
          owe_word(WordFreq, reached, clip, 1'b1);
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      if (errors < MaxPrinted) $display("%0t mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_beat(out_beat_t got);
      out_beat_t want;
      if (owed.size() == 0) begin
        report($sformatf("unexpected beat, index %0d word %h", got.reg_index,
                         got.reg_word));
        return;
      end
      want = owed.pop_front();
      if (got.reg_index !== want.reg_index)
        report($sformatf("reg_index %0d, wanted %0d", got.reg_index, want.reg_index));
      if (got.reg_word !== want.reg_word)
        report($sformatf("reg_word %h, wanted %h (index %0d)", got.reg_word,
                         want.reg_word, want.reg_index));
      if (got.achieved_steps !== want.achieved_steps)
        report($sformatf("achieved_steps %0d, wanted %0d", got.achieved_steps,
                         want.achieved_steps));
      if (got.clipped !== want.clipped)
        report($sformatf("clipped %b, wanted %b", got.clipped, want.clipped));
      if (got.last !== want.last)
        report($sformatf("last %b, wanted %b (index %0d)", got.last, want.last,
                         want.reg_index));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals. Every input of the block starts at a known value.
  // --------------------------------------------------------------------------
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_beat_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_beat_t           out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  word_shadow_sb sb;

  // Idle percentages for each side; the stimulus changes them between phases.
  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 58;

  frac_n_pll_register_builder_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 2 ns period: one nanosecond high, one low.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Receiver. Each beat taken at a rising edge is checked against the oldest
  // owed beat. Ready is redrawn every cycle, except during one long hold-off
  // that starts once enough beats have passed: the sender keeps offering
  // commands meanwhile, so the block fills up and must stall its input.
  // --------------------------------------------------------------------------
  int unsigned beats_seen     = 0;
  int unsigned hold_left      = 0;
  bit          long_hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      sb.check_beat(out_data_o);
      beats_seen++;
    end
    if (!long_hold_done && beats_seen >= LongHoldAfter) begin
      hold_left      = LongHoldCycles;
      long_hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender side.
  // --------------------------------------------------------------------------
  function automatic in_beat_t make_cmd(logic [1:0] mode, logic [StepsW-1:0] steps);
    in_beat_t cmd;
    cmd.mode            = mode;
    cmd.frequency_steps = steps;
    return cmd;
  endfunction

  // Offers one command and returns at the edge where it is taken. Valid is
  // left high so that a following command can go out without a gap; it is
  // only lowered when an idle gap is drawn, so it never falls and rises within
  // one time step.
  task automatic send_command(input in_beat_t cmd);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(cmd);
  endtask

  // Stops offering and waits until every owed beat has arrived, then lets
  // the block idle quietly before returning.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes all five registers on consecutive edges; the enable is lowered
  // once at the end so it is never toggled within a single step.
  task automatic program_settings(input logic [CfgDataW-1:0] mod,
                                  input logic [CfgDataW-1:0] rcnt,
                                  input logic [CfgDataW-1:0] dbl,
                                  input logic [CfgDataW-1:0] half,
                                  input logic [CfgDataW-1:0] div);
    cfg_idx_e              idx [5];
    logic [CfgDataW-1:0]   val [5];
    idx = '{CFG_MODULUS, CFG_R_COUNTER, CFG_REF_DOUBLE, CFG_REF_HALF, CFG_OUT_DIV};
    val = '{mod, rcnt, dbl, half, div};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Random command: mostly real work, some dropped codes. The step count is
  // either fully random, close to the point where INT saturates for the
  // present modulus, or anywhere below it.
  function automatic in_beat_t random_command();
    in_beat_t    cmd;
    int unsigned pick;
    int unsigned m;
    int unsigned lim;
    pick = $urandom_range(99);
    if (pick < 8)       cmd.mode = ModeUnused;
    else if (pick < 25) cmd.mode = MODE_RESTORE;
    else if (pick < 45) cmd.mode = MODE_CLOCK;
    else                cmd.mode = MODE_FREQ;
    m    = (sb.modulus == '0) ? 1 : int'(sb.modulus);
    lim  = (MaxIntVal + 1) * m;
    pick = $urandom_range(99);
    if (pick < 40)      cmd.frequency_steps = StepsW'($urandom);
    else if (pick < 70) cmd.frequency_steps = StepsW'(lim - 2 + $urandom_range(3));
    else                cmd.frequency_steps = StepsW'($urandom_range(lim - 1));
    return cmd;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence: reset, a directed run at the power-on settings, then six
  // phases of random commands, each under fresh settings. The first phases
  // keep the receiver busier idling, the middle ones the sender, and the last
  // two run with neither side idling.
  // --------------------------------------------------------------------------
  initial begin
    in_beat_t    cmd;
    int unsigned done_cnt;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed run with the reset modulus of five, so INT saturates just above
    // 327679 steps. Dropped codes carry extreme step values as well.
    send_command(make_cmd(MODE_RESTORE, '0));
    send_command(make_cmd(MODE_CLOCK, '1));
    send_command(make_cmd(MODE_FREQ, '0));
    send_command(make_cmd(MODE_FREQ, '1));
    send_command(make_cmd(MODE_FREQ, StepsW'(327679)));
    send_command(make_cmd(MODE_FREQ, StepsW'(327680)));
    send_command(make_cmd(MODE_FREQ, StepsW'(123456)));
    send_command(make_cmd(ModeUnused, '1));
    send_command(make_cmd(ModeUnused, '0));
    send_command(make_cmd(MODE_CLOCK, 28'h555_5555));
    send_command(make_cmd(MODE_RESTORE, 28'hAAA_AAAA));
    send_command(make_cmd(MODE_FREQ, 28'h555_5555));
    send_command(make_cmd(MODE_FREQ, 28'hAAA_AAAA));
    drain_and_settle();

    for (int p = 1; p <= 6; p++) begin
      // Both extremes first, including the out-of-range divider values, then
      // a modulus of one and of two, then random register contents.
      case (p)
        1: program_settings(12'd4095, 12'd1023, 12'd1, 12'd1, 12'd7);
        2: program_settings(12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        3: program_settings(12'd1, 12'd1, 12'd1, 12'd0, 12'd3);
        4: program_settings(12'd2, 12'd512, 12'd0, 12'd1, 12'd6);
        default: program_settings(CfgDataW'($urandom), CfgDataW'($urandom),
                                  CfgDataW'($urandom), CfgDataW'($urandom),
                                  CfgDataW'($urandom));
      endcase
      if (p == 3) begin
        send_idle_pct = 58;
        recv_idle_pct = 18;
      end else if (p == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // Merge the new settings into the words before the random mix.
      send_command(make_cmd(MODE_CLOCK, StepsW'($urandom)));
      done_cnt = 1;
      while (done_cnt < ItemsPerPhase) begin
        cmd = random_command();
        send_command(cmd);
        if (cmd.mode != ModeUnused) begin
          done_cnt++;
          // Half way through one phase the sender waits for the block to
          // empty before carrying on.
          if (p == 2 && done_cnt == ItemsPerPhase / 2) drain_and_settle();
        end
      end
      drain_and_settle();
    end

    if (sb.errors == 0) begin
      $display("frac_n_pll_register_builder_top_tb passed");
    end else begin
      $display("frac_n_pll_register_builder_top_tb failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #1_000_000;
    $display("frac_n_pll_register_builder_top_tb failed");
    $finish;
  end

endmodule

// ----- frac_n_pll_register_builder_top.f -----
sv/fnpll_pkg.sv
sv/fnpll_div.sv
sv/frac_n_pll_register_builder_top.sv
tb/sv/frac_n_pll_register_builder_top_tb.sv
